// ----- rtl/core/ste_pkg.sv -----
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the spanning tree enumerator.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int unsigned NodeW = 4;   // vertex id width (fixed by edge fields)
  localparam int unsigned VertN = 16;  // label vector entries

  typedef struct packed {
    logic       kind;
    logic [5:0] edge_slot;
    logic [3:0] end_a;
    logic [3:0] end_b;
  } ste_in_t;

  typedef struct packed {
    logic [5:0] tree_edge;
    logic       found;
    logic       last;
  } ste_out_t;

  typedef logic [VertN*NodeW-1:0] label_vec_t;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StCheck,
    StRdEdge,
    StRdLabel,
    StDecide,
    StPop,
    StPopWait,
    StEmit,
    StEmitWait,
    StNone
  } ste_state_e;

  localparam logic KindLoad = 1'b0;
  localparam logic KindNext = 1'b1;

  localparam logic [0:0] RegNodeCount = 1'b0;
  localparam logic [0:0] RegEdgeCount = 1'b1;

  // Merge the component labeled y into label x.
  function automatic label_vec_t merge_labels(label_vec_t l, logic [NodeW-1:0] x,
                                              logic [NodeW-1:0] y);
    label_vec_t r;
    r = l;
    for (int v = 0; v < VertN; v++) begin
      if (l[v*NodeW +: NodeW] == y) r[v*NodeW +: NodeW] = x;
    end
    return r;
  endfunction

  function automatic label_vec_t identity_labels();
    label_vec_t r;
    for (int v = 0; v < VertN; v++) r[v*NodeW +: NodeW] = NodeW'(v);
    return r;
  endfunction

endpackage

// ----- rtl/core/ste_regs.sv -----
// ----------------------------------------------------------------------------
// ste_regs
// APB register file: node_count and edge_count, restart pulse on write.
// ----------------------------------------------------------------------------
module ste_regs import ste_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  node_count_o,
  output logic [6:0]  edge_count_o,
  output logic        restart_o
);

  logic [4:0] node_q, node_d;
  logic [6:0] edge_q, edge_d;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    node_d    = node_q;
    edge_d    = edge_q;
    restart_o = 1'b0;
    if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        RegNodeCount: begin node_d = pwdata[4:0]; restart_o = 1'b1; end
        RegEdgeCount: begin edge_d = pwdata[6:0]; restart_o = 1'b1; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= 5'd2;
      edge_q <= 7'd1;
    end else begin
      node_q <= node_d;
      edge_q <= edge_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegNodeCount: prdata = {27'd0, node_q};
      RegEdgeCount: prdata = {25'd0, edge_q};
      default: ;
    endcase
  end

  assign node_count_o = node_q;
  assign edge_count_o = edge_q;

endmodule

// ----- rtl/core/spanning_tree_enumerator.sv -----
// ----------------------------------------------------------------------------
// spanning_tree_enumerator
// Backtracking spanning tree enumeration over a stored edge table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat is taken at a clock edge with start high and
//   busy low. kind 0 writes edge_slot := {end_b, end_a} into the edge table
//   and restarts the enumeration (no result). kind 1 resumes the search and
//   returns the next spanning tree as node_count-1 result beats (last on the
//   final one), or a single found=0 beat when the trees are used up, after
//   which enumeration begins again from the first tree.
//   Result channel: each beat is valid_o high for exactly one cycle; the
//   receiver cannot stall. Beats of one tree are spaced by a stack read.
//   Flow: a load is taken in its accepting cycle and busy stays low, so
//   loads can follow back to back. A request begins with a setup step (level
//   zero labels or stack read), then each edge examined passes bound check,
//   edge memory read, label memory read, and decide and label write back;
//   each backtrack passes bound check, stack read and stack data. A complete
//   tree takes one bound check, then a stack read and a result beat per
//   emitted edge. A used-up search ends with a bound check and a result beat.
//   Requests are served by the sequencer's serial walk over the edge memory.
//   Config: APB writes to node_count (0x0) / edge_count (0x4) restart the
//   enumeration. Write only while busy is low.
//   Reset: the stack depth clears to empty; level zero labels are written at
//   the start of every search, so no clearing pass is needed. The edge table
//   is undefined until loaded.
// ----------------------------------------------------------------------------
module spanning_tree_enumerator import ste_pkg::*; #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned MAX_EDGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ste_in_t     in_i,
  output logic        valid_o,
  output ste_out_t    out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LvW = $clog2(MAX_NODES);   // stack depth index width
  localparam int unsigned EiW = $clog2(MAX_EDGES + 1); // edge index incl. end
  localparam int unsigned EaW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned JW  = $clog2(MAX_NODES + 1);

  logic [4:0] node_cfg;
  logic [6:0] edge_cfg;
  logic       cfg_restart;

  ste_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .node_count_o(node_cfg), .edge_count_o(edge_cfg), .restart_o(cfg_restart)
  );

  // effective sizes
  logic [JW-1:0]  n_eff;
  logic [EiW-1:0] m_eff;
  always_comb begin
    if (node_cfg < 5'd2)                       n_eff = JW'(2);
    else if (32'(node_cfg) > MAX_NODES)        n_eff = JW'(MAX_NODES);
    else                                       n_eff = JW'(node_cfg);
    if (32'(edge_cfg) > MAX_EDGES)             m_eff = EiW'(MAX_EDGES);
    else                                       m_eff = EiW'(edge_cfg);
  end

  // memories
  logic [7:0]       edge_mem  [MAX_EDGES];
  logic [EaW-1:0]   chosen_mem[MAX_NODES];
  label_vec_t       label_mem [MAX_NODES];

  logic [7:0]       edge_rd_q;
  logic [EaW-1:0]   chosen_rd_q;
  label_vec_t       label_rd_q;

  ste_state_e       state_q, state_d;
  logic [JW-1:0]    depth_q, depth_d;   // chosen depth
  logic [JW-1:0]    j_q, j_d;
  logic [EiW-1:0]   i_q, i_d;
  logic [JW-1:0]    t_q, t_d;           // emit index

  // memory control
  logic             e_we, c_we, l_we;
  logic [EaW-1:0]   e_wa, e_ra;
  logic [LvW-1:0]   c_wa, c_ra, l_wa, l_ra;
  logic [EaW-1:0]   c_wd;
  label_vec_t       l_wd;

  logic [NodeW-1:0] va, vb, lx, ly;
  logic             accept;

  assign accept = start & ~busy;
  assign busy   = (state_q != StIdle);
  assign va     = edge_rd_q[3:0];
  assign vb     = edge_rd_q[7:4];
  assign lx     = label_rd_q[va*NodeW +: NodeW];
  assign ly     = label_rd_q[vb*NodeW +: NodeW];

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= {in_i.end_b, in_i.end_a};
    edge_rd_q <= edge_mem[e_ra];
  end
  always_ff @(posedge clk_i) begin
    if (c_we) chosen_mem[c_wa] <= c_wd;
    chosen_rd_q <= chosen_mem[c_ra];
  end
  always_ff @(posedge clk_i) begin
    if (l_we) label_mem[l_wa] <= l_wd;
    label_rd_q <= label_mem[l_ra];
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    j_d     = j_q;
    i_d     = i_q;
    t_d     = t_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_i.kind == KindLoad) begin
            depth_d = '0;
          end else begin
            // resume point
            if (depth_q >= n_eff - JW'(1) && depth_q != '0) begin
              j_d     = n_eff - JW'(1);
              depth_d = n_eff - JW'(2);
              state_d = StPopWait;
            end else if (depth_q != '0) begin
              j_d     = depth_q + JW'(1);
              state_d = StPopWait;
            end else begin
              j_d     = JW'(1);
              i_d     = '0;
              state_d = StInit;
            end
          end
        end
      end
      StInit:  state_d = StCheck;
      StPopWait: begin
        // chosen_rd_q holds entry j-1 (j-2 on a resume below full depth); resume after it
        i_d     = EiW'(chosen_rd_q) + EiW'(1);
        state_d = StCheck;
      end
      StCheck: begin
        if (j_q >= n_eff) begin
          t_d     = '0;
          state_d = StEmitWait;
        end else if (32'(m_eff) - 32'(i_q) < 32'(n_eff) - 32'(j_q) ||
                     m_eff < i_q) begin
          if (j_q == JW'(1)) begin
            depth_d = '0;
            state_d = StNone;
          end else begin
            j_d     = j_q - JW'(1);
            depth_d = j_q - JW'(2);
            state_d = StPop;
          end
        end else begin
          state_d = StRdEdge;
        end
      end
      StPop:    state_d = StPopWait;
      StRdEdge: state_d = StRdLabel;
      StRdLabel: state_d = StDecide;
      StDecide: begin
        if (lx != ly) begin
          depth_d = j_q;
          j_d     = j_q + JW'(1);
        end
        i_d     = i_q + EiW'(1);
        state_d = StCheck;
      end
      StEmitWait: state_d = StEmit;
      StEmit: begin
        t_d = t_q + JW'(1);
        if (t_q + JW'(2) >= j_q) state_d = StIdle;
        else                     state_d = StEmitWait;
      end
      StNone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (cfg_restart) begin
      depth_d = '0;
    end
  end

  // memory addressing and outputs
  always_comb begin
    e_we    = 1'b0;
    e_wa    = in_i.edge_slot[EaW-1:0];
    e_ra    = i_q[EaW-1:0];
    c_we    = 1'b0;
    c_wa    = LvW'(j_q - JW'(1));
    c_wd    = EaW'(i_q);
    c_ra    = LvW'(j_q - JW'(2));
    l_we    = 1'b0;
    l_wa    = LvW'(j_q);
    l_wd    = merge_labels(label_rd_q, lx, ly);
    l_ra    = LvW'(j_q - JW'(1));
    valid_o = 1'b0;
    out_o   = '0;
    unique case (state_q)
      StIdle: begin
        e_we = accept && in_i.kind == KindLoad &&
               32'(in_i.edge_slot) < MAX_EDGES;
        c_ra = LvW'(depth_q - JW'(1));
        if (depth_q >= n_eff - JW'(1)) c_ra = LvW'(n_eff - JW'(2));
      end
      StInit: begin
        l_we = 1'b1;
        l_wa = '0;
        l_wd = identity_labels();
      end
      StPop:      c_ra = LvW'(j_q - JW'(1));
      StEmitWait: c_ra = LvW'(t_q);
      StDecide: begin
        c_we = (lx != ly);
        l_we = (lx != ly);
      end
      StEmit: begin
        valid_o         = 1'b1;
        out_o.tree_edge = 6'(chosen_rd_q);
        out_o.found     = 1'b1;
        out_o.last      = (t_q + JW'(2) >= j_q);
      end
      StNone: begin
        valid_o = 1'b1;
        out_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      depth_q <= '0;
      j_q     <= '0;
      i_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      j_q     <= j_d;
      i_q     <= i_d;
      t_q     <= t_d;
    end
  end

  // assertions
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside a request");
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.found) |-> out_o.last) else $error("not-found without last");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.last) |=> !busy) else $error("busy after last beat");

endmodule

// ----- tb/sv/spanning_tree_enumerator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spanning_tree_enumerator_tb
// Self-checking bench: loads edge tables, requests trees, and compares every
// result beat against a local backtracking predictor or a directed expectation.
// ----------------------------------------------------------------------------
module spanning_tree_enumerator_tb;
  import ste_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ste_in_t     in_i = '0;
  logic        valid_o;
  ste_out_t    out_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spanning_tree_enumerator dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---- predictor state: mirror of the enumerator ----
  logic [7:0] edge_mem [64];
  logic [5:0] pick_stk [16];
  int         pick_depth;
  logic [3:0] comp_lbl [16][16];   // [level][vertex]
  logic [4:0] nodes_reg;
  logic [6:0] edges_reg;

  ste_out_t   tree_q[$];           // result beats still owed by the block
  int         mismatches = 0;
  bit         idling_on = 1'b1;

  function automatic void restart_walk();
    pick_depth = 0;
    for (int v = 0; v < 16; v++) comp_lbl[0][v] = 4'(v);
  endfunction

  // Resume the backtracking walk; returns the tree level reached, 0 if used up.
  function automatic int advance_walk();
    int n, m, k, i, j;
    logic [3:0] a, b, x, y;
    n = (nodes_reg < 2) ? 2 : (nodes_reg > 16) ? 16 : int'(nodes_reg);
    m = (edges_reg > 64) ? 64 : int'(edges_reg);
    k = pick_depth;
    if (k >= n - 1 && k > 0) begin
      k = n - 1;
      j = k;
      i = pick_stk[k-1] + 1;
      pick_depth = k - 1;
    end else if (k > 0) begin
      j = k + 1;
      i = pick_stk[k-1] + 1;
    end else begin
      j = 1;
      i = 0;
    end
    while (j < n) begin
      if (m - i < n - j) begin
        // too few edges left for this level: pop one
        j--;
        if (j == 0) begin
          pick_depth = 0;
          return 0;
        end
        i = pick_stk[j-1] + 1;
        pick_depth = j - 1;
      end else begin
        a = edge_mem[i][3:0];
        b = edge_mem[i][7:4];
        x = comp_lbl[j-1][a];
        y = comp_lbl[j-1][b];
        if (x != y) begin
          pick_stk[j-1] = 6'(i);
          pick_depth = j;
          for (int v = 0; v < 16; v++)
            comp_lbl[j][v] = (comp_lbl[j-1][v] == y) ? x : comp_lbl[j-1][v];
          j++;
        end
        i++;
      end
    end
    return j;
  endfunction

  // Apply one accepted beat to the predictor; returns the beats it owes.
  function automatic void predict_beat(ste_in_t it, ref ste_out_t res[$]);
    int cnt;
    ste_out_t r;
    res = {};
    if (it.kind == KindLoad) begin
      edge_mem[it.edge_slot] = {it.end_b, it.end_a};
      restart_walk();
      return;
    end
    cnt = advance_walk();
    if (cnt == 0) begin
      r = '{tree_edge: 6'd0, found: 1'b0, last: 1'b1};
      res = {res, r};
    end else begin
      for (int t = 0; t < cnt - 1; t++) begin
        r = '{tree_edge: pick_stk[t], found: 1'b1, last: (t == cnt - 2)};
        res = {res, r};
      end
    end
  endfunction

  // Drive one beat and hold it until taken; start stays high afterwards.
  task automatic send_beat(ste_in_t it, bit typed, ste_out_t typed_res);
    ste_out_t res[$];
    bit taken;
    start <= 1'b1;
    in_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    predict_beat(it, res);
    if (typed) tree_q = {tree_q, typed_res};
    else tree_q = {tree_q, res};
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Drain everything, then let a trailing load settle before touching registers.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (tree_q.size() != 0 || busy) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegNodeCount) nodes_reg = val[4:0];
    else edges_reg = val[6:0];
    restart_walk();
    @(posedge clk_i);
  endtask

  // ---- result checker ----
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_o);
      end else begin
        if (out_o.tree_edge !== tree_q[0].tree_edge || out_o.found !== tree_q[0].found ||
            out_o.last !== tree_q[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p got %p", tree_q[0], out_o);
        end
        void'(tree_q.pop_front());
      end
    end
  end

  // ---- directed table, run at reset settings (2 nodes, 1 edge) ----
  typedef struct {
    logic       kind;
    logic [5:0] slot;
    logic [3:0] a, b;
    bit         typed;
    ste_out_t   res;
  } dir_row_t;

  localparam ste_out_t TreeE0 = '{6'd0, 1'b1, 1'b1};
  localparam ste_out_t NoTree = '{6'd0, 1'b0, 1'b1};

  dir_row_t dir_rows [] = '{
    '{KindLoad, 6'd0,  4'd0,  4'd1,  1'b0, NoTree},
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, TreeE0},
    '{KindNext, 6'd63, 4'd15, 4'd15, 1'b1, NoTree},  // used up
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, TreeE0},  // wraps to first tree
    '{KindLoad, 6'd0,  4'd15, 4'd15, 1'b0, NoTree},  // self loop
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, NoTree},
    '{KindLoad, 6'd0,  4'd15, 4'd0,  1'b0, NoTree},  // endpoint past node_count
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, TreeE0},
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, NoTree},
    '{KindLoad, 6'd63, 4'd0,  4'd15, 1'b0, NoTree},  // top slot, outside the table
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b1, TreeE0},
    '{KindNext, 6'd0,  4'd0,  4'd0,  1'b0, NoTree}
  };

  initial begin
    ste_in_t it;
    int n_set, m_set, n_eff, m_eff, kind_sel, reqs;

    for (int e = 0; e < 64; e++) edge_mem[e] = '0;
    nodes_reg = 5'd2;
    edges_reg = 7'd1;
    restart_walk();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[r]) begin
      it = '{dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].a, dir_rows[r].b};
      send_beat(it, dir_rows[r].typed, dir_rows[r].res);
      maybe_idle();
    end

    // Phases: each sets registers while idle, fills the table, then requests.
    // Each phase walks one shape, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      kind_sel = ph;
      idling_on = (ph != 3);   // one phase runs flat out
      case (kind_sel)
        0: begin n_set = $urandom_range(2, 4); m_set = $urandom_range(1, 6); end
        1: begin n_set = $urandom_range(0, 1); m_set = $urandom_range(1, 5); end
        2: begin
          n_set = (ph == 2) ? 31 : 16;
          m_set = (ph == 2) ? 127 : 64;
        end
        3: begin n_set = $urandom_range(2, 31); m_set = 0; end
        default: begin n_set = $urandom_range(5, 8); m_set = n_set - 1 + $urandom_range(0, 4); end
      endcase
      reg_write(RegNodeCount, 32'(n_set));
      reg_write(RegEdgeCount, 32'(m_set));
      n_eff = (n_set < 2) ? 2 : (n_set > 16) ? 16 : n_set;
      m_eff = (m_set > 64) ? 64 : m_set;

      // Fill every slot the search can read. From phase 2 on, graphs start with a path so
      // the first trees come fast; the first two phases take any endpoints.
      for (int s = 0; s < m_eff; s++) begin
        it.kind = KindLoad;
        it.edge_slot = 6'(s);
        if (kind_sel >= 2 && s < n_eff - 1) begin
          it.end_a = 4'(s);
          it.end_b = 4'(s + 1);
        end else if (kind_sel >= 2) begin
          it.end_a = 4'($urandom_range(0, n_eff - 1));
          it.end_b = 4'($urandom_range(0, n_eff - 1));
        end else begin
          it.end_a = 4'($urandom_range(0, 15));
          it.end_b = 4'($urandom_range(0, 15));
        end
        send_beat(it, 1'b0, NoTree);
        maybe_idle();
      end

      reqs = $urandom_range(6, 10);
      for (int q = 0; q < reqs; q++) begin
        it = ste_in_t'($bits(ste_in_t)'($urandom()));
        if (kind_sel >= 2 || $urandom_range(0, 99) < 80) begin
          it.kind = KindNext;
        end else begin
          // reload a slot in use, or any slot past the table
          it.kind = KindLoad;
          if (m_eff > 0 && $urandom_range(0, 1)) it.edge_slot = 6'($urandom_range(0, m_eff - 1));
          else if (m_eff < 64) it.edge_slot = 6'($urandom_range(m_eff, 63));
        end
        send_beat(it, 1'b0, NoTree);
        maybe_idle();
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && tree_q.size() == 0) begin
      $display("[spanning_tree_enumerator] OK");
    end else begin
      $display("[spanning_tree_enumerator] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[spanning_tree_enumerator] ERROR");
    $finish;
  end

endmodule
